// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TFN_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define TFN_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define TFN_ASSERT(lbl, clk, rst_n, prop)
`define TFN_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- design/tfn_pkg.sv -----
// ----------------------------------------------------------------------------
// tfn_pkg
// Widths, constants and word types of the triangle face normal unit.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int COORD_BITS       = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NORM_W           = 16;
    localparam int IDX_W            = 32;

    localparam int EDGE_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = CROSS_W;
    localparam int BL_W    = $clog2(MAG_W + 1);
    localparam int R_BITS  = 30;
    localparam int SQ_W    = 2 * R_BITS;
    localparam int RT_W    = 64;
    localparam int SQ_STEPS = RT_W / 2;
    localparam int LEN_W   = R_BITS + 1;
    localparam int QB      = NORMAL_FRAC_BITS + 2;
    localparam int NUM_W   = R_BITS + NORMAL_FRAC_BITS + 1;
    localparam int REM0_W  = NUM_W - QB;

    localparam logic [QB-1:0] SAT_MAX = QB'((1 << (NORM_W - 1)) - 1);

    typedef struct packed {
        logic [2:0][IDX_W-1:0] idx;
        logic [2:0]            neg;
        logic                  degen;
    } t_side;

    typedef struct packed {
        logic [RT_W-1:0]         s;
        logic [RT_W-1:0]         root;
        logic [2:0][R_BITS-1:0]  r;
        t_side                   side;
    } t_sq;

    typedef struct packed {
        logic [LEN_W-1:0]        den;
        logic [2:0][LEN_W-1:0]   rem;
        logic [2:0][QB-1:0]      low;
        logic [2:0][QB-1:0]      quot;
        t_side                   side;
    } t_dv;

endpackage

// ----- design/tfn_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// tfn_sqrt_cell
// One digit step of the integer square root; passes the word to the next cell.
// ----------------------------------------------------------------------------
module tfn_sqrt_cell import tfn_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic [RT_W-1:0] i_bit,
    input  logic            i_valid,
    input  t_sq             i_d,
    output logic            o_valid,
    output t_sq             o_d
);

    logic     r_valid;
    t_sq      r_d;
    t_sq      n_d;
    logic [RT_W-1:0] trial;

    always_comb begin
        n_d   = i_d;
        trial = i_d.root + i_bit;
        if (i_d.s >= trial) begin
            n_d.s    = i_d.s - trial;
            n_d.root = (i_d.root >> 1) + i_bit;
        end else begin
            n_d.root = i_d.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

// ----- design/tfn_div_cell.sv -----
// ----------------------------------------------------------------------------
// tfn_div_cell
// One restoring-division step for all three normal components.
// ----------------------------------------------------------------------------
module tfn_div_cell import tfn_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_dv  i_d,
    output logic o_valid,
    output t_dv  o_d
);

    logic r_valid;
    t_dv  r_d;
    t_dv  n_d;
    logic [LEN_W:0] trial [3];

    always_comb begin
        n_d = i_d;
        for (int i = 0; i < 3; i++) begin
            trial[i]    = {i_d.rem[i], i_d.low[i][QB-1]};
            n_d.low[i]  = {i_d.low[i][QB-2:0], 1'b0};
            if (trial[i] >= {1'b0, i_d.den}) begin
                n_d.rem[i]  = LEN_W'(trial[i] - {1'b0, i_d.den});
                n_d.quot[i] = {i_d.quot[i][QB-2:0], 1'b1};
            end else begin
                n_d.rem[i]  = trial[i][LEN_W-1:0];
                n_d.quot[i] = {i_d.quot[i][QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

// ----- design/triangle_face_normal_unit.sv -----
// ----------------------------------------------------------------------------
// triangle_face_normal_unit
// Unit face normal of one triangle per word, with index pass-through.
// ----------------------------------------------------------------------------
// Accepts one triangle every cycle unless stalled and returns one result word
// per triangle, in order, through 8 stages for edges, cross product,
// magnitude, leading-one detect, alignment, squares and sum, then a chain of
// 32 square-root cells (one root bit per cell), one divider setup stage, a
// chain of 16 divider cells (one quotient bit per cell, three components in
// parallel) and the output register. The whole pipe holds while a finished
// word waits at the output under stall. A zero cross product gives a zero
// normal with the degenerate flag set.
`include "assert_macros.svh"

module triangle_face_normal_unit import tfn_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_v0_x,
    input  logic signed [COORD_BITS-1:0] i_v0_y,
    input  logic signed [COORD_BITS-1:0] i_v0_z,
    input  logic signed [COORD_BITS-1:0] i_v1_x,
    input  logic signed [COORD_BITS-1:0] i_v1_y,
    input  logic signed [COORD_BITS-1:0] i_v1_z,
    input  logic signed [COORD_BITS-1:0] i_v2_x,
    input  logic signed [COORD_BITS-1:0] i_v2_y,
    input  logic signed [COORD_BITS-1:0] i_v2_z,
    input  logic [IDX_W-1:0]             i_corner0_index,
    input  logic [IDX_W-1:0]             i_corner1_index,
    input  logic [IDX_W-1:0]             i_corner2_index,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [IDX_W-1:0]             o_out_index0,
    output logic [IDX_W-1:0]             o_out_index1,
    output logic [IDX_W-1:0]             o_out_index2,
    output logic signed [NORM_W-1:0]     o_normal_x,
    output logic signed [NORM_W-1:0]     o_normal_y,
    output logic signed [NORM_W-1:0]     o_normal_z,
    output logic                         o_degenerate
);

    logic adv;

    logic [8:1] r_v;
    t_side      r_side [1:7];

    logic signed [EDGE_W-1:0]  r_e1 [3];
    logic signed [EDGE_W-1:0]  r_e2 [3];
    logic signed [PROD_W-1:0]  r_p  [6];
    logic signed [CROSS_W-1:0] r_n  [3];
    logic [MAG_W-1:0]          r_mag4 [3];
    logic [MAG_W-1:0]          r_mag5 [3];
    logic [BL_W-1:0]           r_b;
    logic [R_BITS-1:0]         r_r6 [3];
    logic [R_BITS-1:0]         r_r7 [3];
    logic [SQ_W-1:0]           r_sqr [3];
    t_sq                       r_sq0;

    logic [MAG_W-1:0] mx;
    logic [BL_W-1:0]  bl;
    logic [R_BITS-1:0] n_r [3];

    t_sq  sq   [0:SQ_STEPS];
    logic sq_v [0:SQ_STEPS];
    t_dv  dv   [0:QB];
    logic dv_v [0:QB];

    logic r_dv_valid;
    t_dv  r_dv0;
    t_dv  n_dv0;
    logic [NUM_W-1:0] num [3];

    logic                     r_ovalid;
    logic [2:0][IDX_W-1:0]    r_oidx;
    logic [2:0][NORM_W-1:0]   r_onorm;
    logic                     r_odegen;
    logic [2:0][NORM_W-1:0]   n_onorm;
    logic [QB-1:0]            qs;

    logic norm_zero;
    logic norm_unit;

    // pipe moves unless a finished word is held at the output
    assign adv     = !r_ovalid || !i_stall;
    assign o_stall = !adv;

    always_comb begin
        mx = r_mag4[0];
        if (r_mag4[1] > mx) mx = r_mag4[1];
        if (r_mag4[2] > mx) mx = r_mag4[2];
        bl = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (mx[i]) bl = BL_W'(i + 1);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_b <= BL_W'(R_BITS)) begin
                n_r[i] = R_BITS'(r_mag5[i] << (BL_W'(R_BITS) - r_b));
            end else begin
                n_r[i] = R_BITS'(r_mag5[i] >> (r_b - BL_W'(R_BITS)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[7:1], i_valid};
        end
        if (adv) begin
            // edges from vertex 0
            r_e1[0] <= EDGE_W'(i_v1_x) - EDGE_W'(i_v0_x);
            r_e1[1] <= EDGE_W'(i_v1_y) - EDGE_W'(i_v0_y);
            r_e1[2] <= EDGE_W'(i_v1_z) - EDGE_W'(i_v0_z);
            r_e2[0] <= EDGE_W'(i_v2_x) - EDGE_W'(i_v0_x);
            r_e2[1] <= EDGE_W'(i_v2_y) - EDGE_W'(i_v0_y);
            r_e2[2] <= EDGE_W'(i_v2_z) - EDGE_W'(i_v0_z);
            r_side[1].idx   <= {i_corner2_index, i_corner1_index, i_corner0_index};
            r_side[1].neg   <= '0;
            r_side[1].degen <= 1'b0;

            r_p[0] <= r_e1[1] * r_e2[2];
            r_p[1] <= r_e1[2] * r_e2[1];
            r_p[2] <= r_e1[2] * r_e2[0];
            r_p[3] <= r_e1[0] * r_e2[2];
            r_p[4] <= r_e1[0] * r_e2[1];
            r_p[5] <= r_e1[1] * r_e2[0];
            r_side[2] <= r_side[1];

            for (int i = 0; i < 3; i++) begin
                r_n[i] <= CROSS_W'(r_p[2*i]) - CROSS_W'(r_p[2*i+1]);
            end
            r_side[3] <= r_side[2];

            r_side[4].idx   <= r_side[3].idx;
            r_side[4].degen <= r_side[3].degen;
            for (int i = 0; i < 3; i++) begin
                r_mag4[i]         <= r_n[i][CROSS_W-1] ? MAG_W'(-r_n[i]) : MAG_W'(r_n[i]);
                r_side[4].neg[i]  <= r_n[i][CROSS_W-1];
            end

            r_mag5          <= r_mag4;
            r_b             <= bl;
            r_side[5].idx   <= r_side[4].idx;
            r_side[5].neg   <= r_side[4].neg;
            r_side[5].degen <= (mx == '0);

            r_r6      <= n_r;
            r_side[6] <= r_side[5];

            for (int i = 0; i < 3; i++) begin
                r_sqr[i] <= r_r6[i] * r_r6[i];
            end
            r_r7      <= r_r6;
            r_side[7] <= r_side[6];

            r_sq0.s    <= RT_W'(r_sqr[0]) + RT_W'(r_sqr[1]) + RT_W'(r_sqr[2]);
            r_sq0.root <= '0;
            r_sq0.r    <= {r_r7[2], r_r7[1], r_r7[0]};
            r_sq0.side <= r_side[7];
        end
    end

    assign sq[0]   = r_sq0;
    assign sq_v[0] = r_v[8];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        tfn_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_bit   (RT_W'(1) << (RT_W - 2 - 2 * k)),
            .i_valid (sq_v[k]),
            .i_d     (sq[k]),
            .o_valid (sq_v[k+1]),
            .o_d     (sq[k+1])
        );
    end

    // numerator r * 2^frac + len/2; its high part is already below len
    always_comb begin
        n_dv0.den  = sq[SQ_STEPS].root[LEN_W-1:0];
        n_dv0.side = sq[SQ_STEPS].side;
        n_dv0.quot = '0;
        for (int i = 0; i < 3; i++) begin
            num[i] = {1'b0, sq[SQ_STEPS].r[i], NORMAL_FRAC_BITS'(0)}
                   + NUM_W'(sq[SQ_STEPS].root[LEN_W-1:1]);
            n_dv0.rem[i] = LEN_W'(num[i][NUM_W-1:QB]);
            n_dv0.low[i] = num[i][QB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid <= 1'b0;
        end else if (adv) begin
            r_dv_valid <= sq_v[SQ_STEPS];
        end
        if (adv) begin
            r_dv0 <= n_dv0;
        end
    end

    assign dv[0]   = r_dv0;
    assign dv_v[0] = r_dv_valid;

    for (genvar k = 0; k < QB; k++) begin : g_div
        tfn_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (dv_v[k]),
            .i_d     (dv[k]),
            .o_valid (dv_v[k+1]),
            .o_d     (dv[k+1])
        );
    end

    always_comb begin
        qs = '0;
        for (int i = 0; i < 3; i++) begin
            qs = (dv[QB].quot[i] > SAT_MAX) ? SAT_MAX : dv[QB].quot[i];
            if (dv[QB].side.degen) begin
                n_onorm[i] = '0;
            end else if (dv[QB].side.neg[i]) begin
                n_onorm[i] = NORM_W'(-qs);
            end else begin
                n_onorm[i] = NORM_W'(qs);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_ovalid <= dv_v[QB];
        end
        if (adv) begin
            r_oidx   <= dv[QB].side.idx;
            r_onorm  <= n_onorm;
            r_odegen <= dv[QB].side.degen;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_out_index0 = r_oidx[0];
    assign o_out_index1 = r_oidx[1];
    assign o_out_index2 = r_oidx[2];
    assign o_normal_x   = r_onorm[0];
    assign o_normal_y   = r_onorm[1];
    assign o_normal_z   = r_onorm[2];
    assign o_degenerate = r_odegen;

    assign norm_zero = (r_onorm == '0);
    assign norm_unit = (o_normal_x >= -16'sd16384) && (o_normal_x <= 16'sd16384)
                    && (o_normal_y >= -16'sd16384) && (o_normal_y <= 16'sd16384)
                    && (o_normal_z >= -16'sd16384) && (o_normal_z <= 16'sd16384);

    `TFN_ASSERT(a_degen_zero, i_clk, i_rst_n, o_valid && o_degenerate |-> norm_zero)
    `TFN_ASSERT_NEVER(a_live_not_zero, i_clk, i_rst_n, o_valid && !o_degenerate && norm_zero)
    `TFN_ASSERT(a_unit_range, i_clk, i_rst_n, o_valid |-> norm_unit)
    `TFN_ASSERT(a_take_enters, i_clk, i_rst_n, i_valid && !o_stall |=> r_v[1])

endmodule

// ----- bench/triangle_face_normal_unit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal_unit_checker
// Watches both channels, computes the expected face normal of every accepted
// triangle, and compares result words in order against the oldest expectation.
// ----------------------------------------------------------------------------
module triangle_face_normal_unit_checker import tfn_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_in_stall,
    input  logic signed [COORD_BITS-1:0] i_v0_x,
    input  logic signed [COORD_BITS-1:0] i_v0_y,
    input  logic signed [COORD_BITS-1:0] i_v0_z,
    input  logic signed [COORD_BITS-1:0] i_v1_x,
    input  logic signed [COORD_BITS-1:0] i_v1_y,
    input  logic signed [COORD_BITS-1:0] i_v1_z,
    input  logic signed [COORD_BITS-1:0] i_v2_x,
    input  logic signed [COORD_BITS-1:0] i_v2_y,
    input  logic signed [COORD_BITS-1:0] i_v2_z,
    input  logic [IDX_W-1:0]             i_corner0_index,
    input  logic [IDX_W-1:0]             i_corner1_index,
    input  logic [IDX_W-1:0]             i_corner2_index,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [IDX_W-1:0]             i_out_index0,
    input  logic [IDX_W-1:0]             i_out_index1,
    input  logic [IDX_W-1:0]             i_out_index2,
    input  logic signed [NORM_W-1:0]     i_normal_x,
    input  logic signed [NORM_W-1:0]     i_normal_y,
    input  logic signed [NORM_W-1:0]     i_normal_z,
    input  logic                         i_degenerate,
    output int                           o_errors,
    output int                           o_pending,
    output int                           o_results,
    output int                           o_degen_seen
);

    typedef struct {
        logic [IDX_W-1:0]  idx0, idx1, idx2;
        logic [NORM_W-1:0] nx, ny, nz;
        logic              degen;
    } t_normal_word;

    t_normal_word normal_q[$];

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned root, bit_v;
        root  = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > s) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (s >= root + bit_v) begin
                s    = s - (root + bit_v);
                root = (root >> 1) + bit_v;
            end else begin
                root = root >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return root;
    endfunction

    function automatic t_normal_word face_normal(
        longint ax0, longint ay0, longint az0, longint ax1, longint ay1,
        longint az1, longint ax2, longint ay2, longint az2,
        logic [IDX_W-1:0] c0, logic [IDX_W-1:0] c1, logic [IDX_W-1:0] c2);
        t_normal_word    w;
        longint          n[3];
        longint unsigned mg[3];
        longint unsigned m, sum, len, q;
        int              blen;
        n[0] = (ay1 - ay0) * (az2 - az0) - (az1 - az0) * (ay2 - ay0);
        n[1] = (az1 - az0) * (ax2 - ax0) - (ax1 - ax0) * (az2 - az0);
        n[2] = (ax1 - ax0) * (ay2 - ay0) - (ay1 - ay0) * (ax2 - ax0);
        w.idx0 = c0; w.idx1 = c1; w.idx2 = c2;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = (n[i] < 0) ? -n[i] : n[i];
            if (mg[i] > m) m = mg[i];
        end
        w.nx = '0; w.ny = '0; w.nz = '0;
        w.degen = (m == 0);
        if (m == 0) return w;
        blen = 0;
        while ((m >> blen) != 0) blen++;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            if (blen <= R_BITS) mg[i] = mg[i] << (R_BITS - blen);
            else                mg[i] = mg[i] >> (blen - R_BITS);
            sum += mg[i] * mg[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((mg[i] << NORMAL_FRAC_BITS) + (len >> 1)) / len;
            if (q > 32767) q = 32767;
            if (n[i] < 0) q = -q;
            if (i == 0) w.nx = q[NORM_W-1:0];
            else if (i == 1) w.ny = q[NORM_W-1:0];
            else w.nz = q[NORM_W-1:0];
        end
        return w;
    endfunction

    // append one expectation at the tail of the queue
    task automatic add_expect(input t_normal_word w);
        normal_q.insert(normal_q.size(), w);
    endtask

    assign o_pending = normal_q.size();

    always @(posedge i_clk) begin
        t_normal_word e;
        if (!i_rst_n) begin
            o_errors     <= 0;
            o_results    <= 0;
            o_degen_seen <= 0;
            normal_q.delete();
        end else begin
            if (i_valid && !i_in_stall)
                add_expect(face_normal(i_v0_x, i_v0_y, i_v0_z, i_v1_x,
                    i_v1_y, i_v1_z, i_v2_x, i_v2_y, i_v2_z, i_corner0_index,
                    i_corner1_index, i_corner2_index));
            if (i_out_valid && !i_out_stall) begin
                o_results <= o_results + 1;
                if (i_degenerate) o_degen_seen <= o_degen_seen + 1;
                if (normal_q.size() == 0) begin
                    $error("result word with no expectation waiting");
                    o_errors <= o_errors + 1;
                end else begin
                    e = normal_q.pop_front();
                    if ({i_out_index0, i_out_index1, i_out_index2, i_normal_x,
                         i_normal_y, i_normal_z, i_degenerate} !==
                        {e.idx0, e.idx1, e.idx2, e.nx, e.ny, e.nz, e.degen}) begin
                        o_errors <= o_errors + 1;
                        if (i_out_index0 !== e.idx0)
                            $error("out_index0 exp %h got %h", e.idx0, i_out_index0);
                        if (i_out_index1 !== e.idx1)
                            $error("out_index1 exp %h got %h", e.idx1, i_out_index1);
                        if (i_out_index2 !== e.idx2)
                            $error("out_index2 exp %h got %h", e.idx2, i_out_index2);
                        if (i_normal_x !== e.nx)
                            $error("normal_x exp %h got %h", e.nx, i_normal_x);
                        if (i_normal_y !== e.ny)
                            $error("normal_y exp %h got %h", e.ny, i_normal_y);
                        if (i_normal_z !== e.nz)
                            $error("normal_z exp %h got %h", e.nz, i_normal_z);
                        if (i_degenerate !== e.degen)
                            $error("degenerate exp %b got %b", e.degen, i_degenerate);
                    end
                end
            end
        end
    end

endmodule

// ----- bench/triangle_face_normal_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal_unit_tb
// Drives directed and random triangles with bursty input and a stalling
// output, including one long hold-off that fills the pipe.
// ----------------------------------------------------------------------------
module triangle_face_normal_unit_tb;
    import tfn_pkg::*;

    localparam int N_RANDOM = 500;
    localparam int LATENCY  = 58;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, o_valid, i_stall;
    logic signed [COORD_BITS-1:0] vc[9];
    logic [IDX_W-1:0] ci[3];
    logic [IDX_W-1:0] o_out_index0, o_out_index1, o_out_index2;
    logic signed [NORM_W-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic o_degenerate;
    int   errors, pending, results, degen_seen;
    int   sent;
    bit   hold_off_req, hold_off_done;

    triangle_face_normal_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_v0_x(vc[0]), .i_v0_y(vc[1]), .i_v0_z(vc[2]),
        .i_v1_x(vc[3]), .i_v1_y(vc[4]), .i_v1_z(vc[5]),
        .i_v2_x(vc[6]), .i_v2_y(vc[7]), .i_v2_z(vc[8]),
        .i_corner0_index(ci[0]), .i_corner1_index(ci[1]), .i_corner2_index(ci[2]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_index0(o_out_index0), .o_out_index1(o_out_index1),
        .o_out_index2(o_out_index2), .o_normal_x(o_normal_x),
        .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_degenerate(o_degenerate)
    );

    triangle_face_normal_unit_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_in_stall(o_stall),
        .i_v0_x(vc[0]), .i_v0_y(vc[1]), .i_v0_z(vc[2]),
        .i_v1_x(vc[3]), .i_v1_y(vc[4]), .i_v1_z(vc[5]),
        .i_v2_x(vc[6]), .i_v2_y(vc[7]), .i_v2_z(vc[8]),
        .i_corner0_index(ci[0]), .i_corner1_index(ci[1]), .i_corner2_index(ci[2]),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_out_index0(o_out_index0), .i_out_index1(o_out_index1),
        .i_out_index2(o_out_index2), .i_normal_x(o_normal_x),
        .i_normal_y(o_normal_y), .i_normal_z(o_normal_z),
        .i_degenerate(o_degenerate), .o_errors(errors), .o_pending(pending),
        .o_results(results), .o_degen_seen(degen_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("triangle_face_normal_unit_tb: done, errors");
        $finish;
    end

    // offer one word, hold until accepted; valid stays up between back-to-back words
    task automatic send_triangle(input logic [15:0] c[9], input logic [31:0] ix[3]);
        for (int i = 0; i < 9; i++) vc[i] <= c[i];
        for (int i = 0; i < 3; i++) ci[i] <= ix[i];
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic idle_gap(input int n);
        i_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_coord(input int mode);
        case (mode)
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver: random stall pattern plus one long hold-off on request
    initial begin
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_off_done) begin
                i_stall <= 1'b1;
                repeat (200) @(negedge i_clk);
                hold_off_done = 1'b1;
                i_stall <= 1'b0;
            end else begin
                case ((results / 64) % 3)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    default: i_stall <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    initial begin
        logic [15:0] c[9];
        logic [31:0] ix[3];
        int          mode, wait_cnt;
        sent = 0;
        hold_off_req = 1'b0;
        i_valid = 1'b0;
        for (int i = 0; i < 9; i++) vc[i] = '0;
        for (int i = 0; i < 3; i++) ci[i] = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, degenerate shapes, axis-aligned and tiny triangles
        for (int t = 0; t < 20; t++) begin
            for (int i = 0; i < 9; i++) c[i] = '0;
            ix[0] = (t % 2) ? 32'hffff_ffff : 32'h0;
            ix[1] = 32'h5555_5555 ^ {32{t[0]}};
            ix[2] = 32'(t);
            case (t)
                0: ;                                          // all coincident
                1: begin c[3] = 16'd256; c[6] = 16'd512; end  // collinear
                2: begin c[3] = 16'd256; c[7] = 16'd256; end  // +z normal
                3: begin c[3] = 16'd256; c[8] = 16'd256; end  // -y normal
                4: begin c[4] = 16'd256; c[8] = 16'd256; end  // +x normal
                5: begin c[3] = 16'd1; c[7] = 16'd1; end      // smallest cross
                6: begin c[0] = 16'h8000; c[1] = 16'h8000; c[2] = 16'h8000;
                         c[3] = 16'h7fff; c[4] = 16'h8000; c[5] = 16'h8000;
                         c[6] = 16'h8000; c[7] = 16'h7fff; c[8] = 16'h8000; end
                7: begin c[0] = 16'h7fff; c[1] = 16'h8000; c[2] = 16'h7fff;
                         c[3] = 16'h8000; c[4] = 16'h7fff; c[5] = 16'h8000;
                         c[6] = 16'h7fff; c[7] = 16'h7fff; c[8] = 16'h8000; end
                8: for (int i = 0; i < 9; i++) c[i] = 16'h7fff;
                9: for (int i = 0; i < 9; i++) c[i] = pick_coord(i % 2);
                10: begin c[3] = 16'd100; c[4] = 16'd100; c[5] = 16'd100;
                          c[6] = 16'hff9c; c[7] = 16'd100; c[8] = 16'hff9c; end
                default: for (int i = 0; i < 9; i++) c[i] = pick_coord($urandom_range(0, 3));
            endcase
            send_triangle(c, ix);
        end
        idle_gap(3);

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == 150) hold_off_req = 1'b1;
            mode = $urandom_range(0, 9);
            for (int i = 0; i < 9; i++) c[i] = pick_coord($urandom_range(2, 3));
            if (mode == 0) for (int i = 3; i < 9; i++) c[i] = c[i % 3];  // degenerate
            else if (mode == 1) for (int i = 0; i < 9; i++) c[i] = pick_coord($urandom_range(0, 1));
            else if (mode == 2) for (int i = 6; i < 9; i++) c[i] = c[i - 3];
            for (int i = 0; i < 3; i++) ix[i] = $urandom;
            send_triangle(c, ix);
            // bursts with random gaps; some long stretches run back to back
            if ((k / 100) % 2 == 0 && $urandom_range(0, 7) == 0)
                idle_gap($urandom_range(1, 12));
        end
        i_valid <= 1'b0;

        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 200000) begin
            @(negedge i_clk);
            wait_cnt++;
        end
        repeat (2 * LATENCY) @(negedge i_clk);
        $display("covered %0d triangles, %0d results, %0d degenerate",
                 sent, results, degen_seen);
        $display("including extreme coordinates and a long output hold-off");
        if (errors == 0 && pending == 0)
            $display("triangle_face_normal_unit_tb: done, clean");
        else
            $display("triangle_face_normal_unit_tb: done, errors");
        $finish;
    end

endmodule
